>>> src/assert_macros.svh
// Assertion macros used by the RTL file of the chunked body decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequence holds in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequence holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hcbd_pkg.sv
// Types, constants and helper functions of the chunked body decoder.
package hcbd_pkg;

    // Default widths of the size counter and the payload counter.
    localparam int SIZE_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int BYTE_W      = 8;
    localparam int COUNT_OUT_W = 16;
    localparam int M_TDATA_W   = 32;

    // Line delimiter characters.
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_HDR   = 3'd1,
        PH_SIZE  = 3'd2,
        PH_EXT   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CR    = 3'd5,
        PH_LF    = 3'd6,
        PH_DONE  = 3'd7
    } phase_t;

    // Outcome reported with each result.
    typedef enum logic [2:0] {
        ST_RUNNING     = 3'd0,
        ST_ZERO_CHUNK  = 3'd1,
        ST_CLEAN_END   = 3'd2,
        ST_SHORT_CHUNK = 3'd3,
        ST_NO_CRLF     = 3'd4,
        ST_NO_HDR_END  = 3'd5,
        ST_SIZE_OVFL   = 3'd6
    } status_t;

    // Decoded hex digit: a flag for a valid digit and its value.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decodes one ASCII hex digit, upper or lower case.
    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] b);
        hex_digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.valid = 1'b1;
            d.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d.valid = 1'b1;
            d.value = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d.valid = 1'b1;
            d.value = 4'(b - 8'h57);
        end
        return d;
    endfunction

endpackage

>>> src/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked transfer-coding body decoder.
//
// The slave channel takes one received byte per transaction; tlast marks the
// final byte of a received buffer. Every input transaction yields exactly one
// result transaction on the master channel, in the cycle after acceptance. The
// result flags a decoded payload byte in tuser and carries the byte, the
// status code, a finished flag and the saturating payload count in tdata.
// Throughput is one byte per cycle when not stalled: the whole decode step is
// a small state update between the state registers and the result register.
// skip_headers must be written through cfg_we/cfg_wdata only while idle,
// unchecked by the block; it is sampled on the first byte of each buffer; when
// set, bytes up to the blank line ending the headers are consumed first. Reset
// clears the phase, the counters, the result valid flag and sets skip_headers;
// no clearing pass is needed. When the receiver stalls, the result is held in
// the output register and s_axis_tready falls until it is taken; a result taken
// in the same cycle frees the register for the next byte at once.
`include "assert_macros.svh"

module http_chunked_body_decoder #(
    parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: skip_headers.
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hcbd_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic                          s_axis_tlast,   // last_byte
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hcbd_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_byte,
                                                          // [10:8] status,
                                                          // [11] final_res,
                                                          // [27:12] decoded_count,
                                                          // [31:28] zero
    output logic                          m_axis_tuser    // out_valid
);

    localparam int CNT_EXT_W = (COUNT_BITS > hcbd_pkg::COUNT_OUT_W) ?
                               COUNT_BITS : hcbd_pkg::COUNT_OUT_W;
    localparam int PAD_W     = hcbd_pkg::M_TDATA_W - hcbd_pkg::COUNT_OUT_W - 1 - 3
                               - hcbd_pkg::BYTE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration register.
    logic skip_headers_reg;

    // Decoder state.
    hcbd_pkg::phase_t        phase_reg, phase_next, phase_step, phase_eff;
    logic [1:0]              dmatch_reg, dmatch_next;
    logic [SIZE_BITS-1:0]    acc_reg, acc_next, acc_step;
    logic                    digit_reg, digit_next;
    logic [SIZE_BITS-1:0]    remain_reg, remain_next, remain_dec;
    logic [COUNT_BITS-1:0]   count_reg, count_next, count_step;

    // Step results of the decode logic.
    logic                    step_fin;
    hcbd_pkg::status_t       step_status;
    hcbd_pkg::hex_digit_t    hex;

    // Result fields.
    logic                    res_valid;
    logic [hcbd_pkg::BYTE_W-1:0] res_byte;
    hcbd_pkg::status_t       res_status;
    logic                    res_fin;
    logic [CNT_EXT_W-1:0]    count_ext;

    // Output register.
    logic                    m_valid_reg;
    logic                    o_valid_reg;
    logic [hcbd_pkg::BYTE_W-1:0] o_byte_reg;
    hcbd_pkg::status_t       o_status_reg;
    logic                    o_fin_reg;
    logic [hcbd_pkg::COUNT_OUT_W-1:0] o_count_reg;

    logic s_fire;
    logic was_done;

    // A new byte is taken whenever the output register is free or being emptied.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign hex        = hcbd_pkg::hex_decode(s_axis_tdata);
    assign was_done   = (phase_reg == hcbd_pkg::PH_DONE);
    assign remain_dec = (remain_reg != '0) ? remain_reg - SIZE_BITS'(1) : remain_reg;

    // Next-state logic: one decode step, then a rearm on the buffer's last byte.
    always_comb begin
        phase_eff = phase_reg;
        if (phase_reg == hcbd_pkg::PH_START) begin
            phase_eff = skip_headers_reg ? hcbd_pkg::PH_HDR : hcbd_pkg::PH_SIZE;
        end
        phase_step  = phase_eff;
        dmatch_next = dmatch_reg;
        acc_step    = acc_reg;
        digit_next  = digit_reg;
        remain_next = remain_reg;
        count_step  = count_reg;
        step_fin    = 1'b0;
        step_status = hcbd_pkg::ST_RUNNING;

        unique case (phase_eff)
            hcbd_pkg::PH_HDR: begin
                if (s_axis_tdata == (dmatch_reg[0] ? hcbd_pkg::CHAR_LF : hcbd_pkg::CHAR_CR)) begin
                    if (dmatch_reg == 2'd3) begin
                        dmatch_next = 2'd0;
                        phase_step  = hcbd_pkg::PH_SIZE;
                    end else begin
                        dmatch_next = dmatch_reg + 2'd1;
                    end
                end else begin
                    dmatch_next = (s_axis_tdata == hcbd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            hcbd_pkg::PH_SIZE: begin
                if (hex.valid) begin
                    if (acc_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                        step_fin    = 1'b1;
                        step_status = hcbd_pkg::ST_SIZE_OVFL;
                        phase_step  = hcbd_pkg::PH_DONE;
                    end else begin
                        acc_step   = {acc_reg[SIZE_BITS-5:0], hex.value};
                        digit_next = 1'b1;
                    end
                end else begin
                    dmatch_next = (s_axis_tdata == hcbd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                    phase_step  = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_EXT: begin
                if (dmatch_reg == 2'd1 && s_axis_tdata == hcbd_pkg::CHAR_LF) begin
                    dmatch_next = 2'd0;
                    if (!digit_reg || acc_reg == '0) begin
                        step_fin    = 1'b1;
                        step_status = hcbd_pkg::ST_ZERO_CHUNK;
                        phase_step  = hcbd_pkg::PH_DONE;
                    end else begin
                        remain_next = acc_reg;
                        acc_step    = '0;
                        digit_next  = 1'b0;
                        phase_step  = hcbd_pkg::PH_DATA;
                    end
                end else begin
                    dmatch_next = (s_axis_tdata == hcbd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            hcbd_pkg::PH_DATA: begin
                if (count_reg != COUNT_MAX) begin
                    count_step = count_reg + COUNT_BITS'(1);
                end
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    phase_step = hcbd_pkg::PH_CR;
                end
            end
            hcbd_pkg::PH_CR: begin
                if (s_axis_tdata == hcbd_pkg::CHAR_CR) begin
                    phase_step = hcbd_pkg::PH_LF;
                end else begin
                    step_fin    = 1'b1;
                    step_status = hcbd_pkg::ST_NO_CRLF;
                    phase_step  = hcbd_pkg::PH_DONE;
                end
            end
            hcbd_pkg::PH_LF: begin
                if (s_axis_tdata == hcbd_pkg::CHAR_LF) begin
                    phase_step = hcbd_pkg::PH_SIZE;
                end else begin
                    step_fin    = 1'b1;
                    step_status = hcbd_pkg::ST_NO_CRLF;
                    phase_step  = hcbd_pkg::PH_DONE;
                end
            end
            hcbd_pkg::PH_START,
            hcbd_pkg::PH_DONE: begin
                // Finished bytes leave the state untouched.
            end
        endcase

        // Rearm after the last byte of a buffer.
        phase_next = phase_step;
        acc_next   = acc_step;
        count_next = count_step;
        if (s_axis_tlast) begin
            phase_next  = hcbd_pkg::PH_START;
            dmatch_next = 2'd0;
            acc_next    = '0;
            digit_next  = 1'b0;
            remain_next = '0;
            count_next  = '0;
        end
    end

    // Output logic: payload byte, and the buffer-end report where none was given.
    always_comb begin
        res_valid  = (phase_eff == hcbd_pkg::PH_DATA);
        res_byte   = res_valid ? s_axis_tdata : '0;
        res_fin    = step_fin;
        res_status = step_status;
        if (s_axis_tlast && !step_fin && !was_done) begin
            res_fin = 1'b1;
            unique case (phase_step)
                hcbd_pkg::PH_HDR: res_status = hcbd_pkg::ST_NO_HDR_END;
                hcbd_pkg::PH_SIZE,
                hcbd_pkg::PH_EXT: res_status = (acc_step == '0) ?
                                               hcbd_pkg::ST_CLEAN_END :
                                               hcbd_pkg::ST_SHORT_CHUNK;
                hcbd_pkg::PH_DATA: res_status = hcbd_pkg::ST_SHORT_CHUNK;
                default: res_status = hcbd_pkg::ST_NO_CRLF;
            endcase
        end
        count_ext = CNT_EXT_W'(count_step);
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_headers_reg <= 1'b1;
        end else if (cfg_we) begin
            skip_headers_reg <= cfg_wdata;
        end
    end

    // Decoder state, updated once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= hcbd_pkg::PH_START;
            dmatch_reg <= 2'd0;
            acc_reg    <= '0;
            digit_reg  <= 1'b0;
            remain_reg <= '0;
            count_reg  <= '0;
        end else if (s_fire) begin
            phase_reg  <= phase_next;
            dmatch_reg <= dmatch_next;
            acc_reg    <= acc_next;
            digit_reg  <= digit_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            o_valid_reg  <= res_valid;
            o_byte_reg   <= res_byte;
            o_status_reg <= res_status;
            o_fin_reg    <= res_fin;
            o_count_reg  <= count_ext[hcbd_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = o_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, o_count_reg, o_fin_reg, o_status_reg, o_byte_reg};

    // A result without a payload byte carries a zero byte.
    `ASSERT_SAME(a_byte_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser,
                 m_axis_tdata[7:0] == 8'd0, "payload byte not zero without out_valid")
    // A finished result always names an outcome.
    `ASSERT_SAME(a_fin_status, aclk, aresetn, m_axis_tvalid && m_axis_tdata[11],
                 m_axis_tdata[10:8] != 3'd0, "finished result with running status")
    // The last byte of a buffer always rearms the decoder.
    `ASSERT_NEXT(a_rearm, aclk, aresetn, s_fire && s_axis_tlast,
                 phase_reg == hcbd_pkg::PH_START, "decoder not rearmed after last byte")
    // Chunk data phase always has bytes left to pass.
    `ASSERT_ALWAYS(a_data_remain, aclk, aresetn,
                   phase_reg != hcbd_pkg::PH_DATA || remain_reg != '0,
                   "data phase with no bytes remaining")

endmodule
